// ----- design/prm_pkg.sv -----
// Package for the page residency manager: codes, state type and default sizes.
// Used by page_residency_manager, prm_checker and the testbench.
`default_nettype none
package prm_pkg;

  localparam int PageSlotsDef     = 32;
  localparam int MaxPrioritiesDef = 8;
  localparam int DirtyListsDef    = 8;
  localparam int RefBitsDef       = 16;

  // action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_USE    = 3'd1;
  localparam logic [2:0] ACT_REL    = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_FLUSH  = 3'd5;
  localparam logic [2:0] ACT_RDUSE  = 3'd6;
  localparam logic [2:0] ACT_RDMAP  = 3'd7;

  // result kinds
  localparam logic [2:0] KIND_DONE  = 3'd0;
  localparam logic [2:0] KIND_EVICT = 3'd1;
  localparam logic [2:0] KIND_MAP   = 3'd2;
  localparam logic [2:0] KIND_UNMAP = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ABSENT = 3'd1;
  localparam logic [2:0] ST_UNUSED = 3'd2;
  localparam logic [2:0] ST_BUSY   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // config register indexes
  localparam logic CFG_LIMIT  = 1'b0;
  localparam logic CFG_LEVELS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_EVCHK, S_EVICT, S_MAP, S_FLUSH, S_RMV, S_DONE
  } state_t;

  typedef enum logic [1:0] {Q_NONE, Q_PUSH, Q_UNLINK} q_op_t;

endpackage
`default_nettype wire

// ----- design/page_residency_manager.sv -----
// Top level of the page residency manager: slot table, idle and dirty queues.
// Depends on prm_pkg and prm_attr_mem.
//
//  channel   direction  handshake                fields
//  s_axis    in         s_tvalid/s_tready        tuser action, tdata page..sync_wait
//  m_axis    out        m_tvalid/m_tready        tuser kind, tlast last, tdata rest
//  cfg       in         cfg_we (no wait)         index, 32-bit data
//
// One transaction at a time. Lookup follows accept, then the done result; each
// evicted page takes a victim attribute read, then a pop; each empty idle queue
// is searched in turn, and each flushed or cleared page is popped on its own.
// Reset is synchronous; all queues empty and all slots absent at once.
// A stalled output holds the sequencer; input is taken only when idle.
`default_nettype none
module page_residency_manager
  import prm_pkg::*;
#(
  parameter int PAGE_SLOTS     = PageSlotsDef,
  parameter int MAX_PRIORITIES = MaxPrioritiesDef,
  parameter int DIRTY_LISTS    = DirtyListsDef,
  parameter int REF_BITS       = RefBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // action
  input  wire logic [47:0] s_tdata,   // page, page_size, priority_req, dirty_list,
                                      // mark_dirty, writable, sync_wait, zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [2:0]       m_tuser,   // kind
  output logic             m_tlast,   // last
  output logic [47:0]      m_tdata,   // page_out, writable_out, sync_out, value,
                                      // status, zero pad
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SW  = $clog2(PAGE_SLOTS);
  localparam int LW  = $clog2(PAGE_SLOTS + 1);
  localparam int PW  = (MAX_PRIORITIES > 1) ? $clog2(MAX_PRIORITIES) : 1;
  localparam int DW  = (DIRTY_LISTS > 1) ? $clog2(DIRTY_LISTS) : 1;
  localparam int PRW = $clog2(MAX_PRIORITIES + 1);
  localparam int TW  = 32 + SW + 1;
  localparam int MW  = DW + 1 + PW + 32;
  localparam logic [LW-1:0] NIL = LW'(PAGE_SLOTS);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  // config
  logic [31:0] limit;
  logic [3:0]  levels;

  // slot state
  logic                present [PAGE_SLOTS];
  logic                mapped  [PAGE_SLOTS];
  logic                dirty   [PAGE_SLOTS];
  logic [REF_BITS-1:0] refs    [PAGE_SLOTS];
  logic [LW-1:0] inext [PAGE_SLOTS];
  logic [LW-1:0] iprev [PAGE_SLOTS];
  logic [LW-1:0] ihead [MAX_PRIORITIES];
  logic [LW-1:0] itail [MAX_PRIORITIES];
  logic [LW-1:0] dnext [PAGE_SLOTS];
  logic [LW-1:0] dprev [PAGE_SLOTS];
  logic [LW-1:0] dhead [DIRTY_LISTS];
  logic [LW-1:0] dtail [DIRTY_LISTS];
  logic [TW-1:0] total;
  logic [31:0]   map_events;

  // command latch
  state_t      state, state_next;
  logic [2:0]  c_act;
  logic [4:0]  c_page;
  logic [31:0] c_size;
  logic [2:0]  c_prio;
  logic [2:0]  c_list;
  logic        c_md, c_wr, c_sync;
  logic [31:0] psize;
  logic        pwr;
  logic [PW-1:0] pprio;
  logic [DW-1:0] plist;
  logic [PRW-1:0] pr;
  logic [31:0] dval;
  logic [2:0]  dst;

  // memory
  logic          mem_we;
  logic [SW-1:0] mem_ra;
  logic [MW-1:0] mem_wd, mem_rd;
  logic [31:0]   rd_size;
  logic [PW-1:0] rd_prio;
  logic          rd_wr;
  logic [DW-1:0] rd_list;

  prm_attr_mem #(.DEPTH(PAGE_SLOTS), .AW(SW), .DW(MW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(SW'(c_page)),
    .wdata(mem_wd),
    .raddr(mem_ra),
    .rdata(mem_rd)
  );

  assign rd_size = mem_rd[31:0];
  assign rd_prio = mem_rd[32 +: PW];
  assign rd_wr   = mem_rd[32 + PW];
  assign rd_list = mem_rd[33 + PW +: DW];

  // decode of the held command
  logic          pin, here, can_emit, lin, ev_cond;
  logic [SW-1:0] pi;
  logic [DW-1:0] li;
  logic [PRW-1:0] lv;
  logic [LW-1:0] vic, fhead;
  logic [PW-1:0] prio_cl;
  logic [DW-1:0] list_cl;
  logic [31:0]   lk_val;
  logic [2:0]    lk_st;

  assign pin  = 32'(c_page) < PAGE_SLOTS;
  assign pi   = SW'(c_page);
  assign here = pin && present[pi];
  assign lin  = 32'(c_list) < DIRTY_LISTS;
  assign li   = DW'(c_list);
  assign fhead = lin ? dhead[li] : NIL;
  assign vic  = ihead[PW'(pr)];
  assign can_emit = !m_tvalid || m_tready;
  assign prio_cl = (32'(c_prio) < MAX_PRIORITIES) ? PW'(c_prio) : PW'(MAX_PRIORITIES - 1);
  assign list_cl = (32'(c_list) < DIRTY_LISTS) ? DW'(c_list) : DW'(DIRTY_LISTS - 1);
  assign mem_wd = {list_cl, c_wr, prio_cl, c_size};

  always_comb begin
    if (levels == 4'd0) lv = PRW'(1);
    else if (32'(levels) > MAX_PRIORITIES) lv = PRW'(MAX_PRIORITIES);
    else lv = PRW'(levels);
  end

  assign ev_cond = ((total + TW'(psize)) >= TW'(limit)) && (pr < lv);

  // decide the done value and status at lookup
  always_comb begin
    lk_val = '0;
    lk_st  = ST_OK;
    case (c_act)
      ACT_RDUSE: begin
        lk_val = here ? 32'(refs[pi]) : '0;
        lk_st  = here ? ST_OK : ST_ABSENT;
      end
      ACT_RDMAP: lk_val = map_events;
      ACT_ADD: begin
        if (!pin) lk_st = ST_ABSENT;
        else if (present[pi]) lk_st = ST_BUSY;
      end
      ACT_USE: begin
        if (!here) lk_st = ST_ABSENT;
        else if (refs[pi] == REF_MAX) begin
          lk_st = ST_FULL; lk_val = 32'(refs[pi]);
        end else if (refs[pi] != '0 || mapped[pi]) begin
          lk_val = 32'(refs[pi]) + 32'd1;
        end
      end
      ACT_REL: begin
        if (!here) lk_st = ST_ABSENT;
        else if (refs[pi] == '0) lk_st = ST_UNUSED;
        else lk_val = 32'(refs[pi]) - 32'd1;
      end
      ACT_REMOVE: if (!here) lk_st = ST_ABSENT;
      default: ;
    endcase
  end

  // queue operations and emission
  q_op_t         iop, dop;
  logic [PW-1:0] iq;
  logic [DW-1:0] dq;
  logic [SW-1:0] ix, dx;
  logic          emit, e_wr, e_sync, e_last;
  logic [2:0]    e_kind, e_st;
  logic [4:0]    e_page;
  logic [31:0]   e_val;

  always_comb begin
    iop = Q_NONE; iq = rd_prio; ix = pi;
    dop = Q_NONE; dq = rd_list; dx = pi;
    emit = 1'b0; e_kind = KIND_DONE; e_page = '0; e_wr = 1'b0; e_sync = 1'b0;
    e_val = '0; e_st = ST_OK; e_last = 1'b0;
    mem_we = 1'b0;
    mem_ra = pi;
    unique case (state)
      S_IDLE: mem_ra = SW'(s_tdata[4:0]);
      S_LOOK: begin
        if (c_act == ACT_ADD) begin
          mem_we = pin && !present[pi];
        end else if (c_act == ACT_USE) begin
          if (here && refs[pi] != REF_MAX && !(refs[pi] == '0 && !mapped[pi])) begin
            if (refs[pi] == '0) iop = Q_UNLINK;
            if (c_md && !dirty[pi]) dop = Q_PUSH;
          end
        end else if (c_act == ACT_REL) begin
          if (here && refs[pi] == REF_BITS'(1)) iop = Q_PUSH;
        end
      end
      S_EVCHK: mem_ra = vic[SW-1:0];
      S_EVICT: begin
        // keep the victim's attributes on the read port while stalled
        mem_ra = vic[SW-1:0];
        if (can_emit) begin
          emit = 1'b1; e_kind = KIND_EVICT; e_page = 5'(vic[SW-1:0]);
          iop = Q_UNLINK; iq = PW'(pr); ix = vic[SW-1:0];
          if (dirty[vic[SW-1:0]]) begin
            dop = Q_UNLINK; dx = vic[SW-1:0];
          end
        end
      end
      S_MAP: begin
        if (can_emit) begin
          emit = 1'b1; e_kind = KIND_MAP; e_page = c_page; e_wr = pwr;
          if (c_md && !dirty[pi]) begin
            dop = Q_PUSH; dq = plist;
          end
        end
      end
      S_FLUSH: begin
        if (fhead != NIL && (c_act == ACT_CLEAR || can_emit)) begin
          dop = Q_UNLINK; dq = li; dx = fhead[SW-1:0];
          if (c_act == ACT_FLUSH) begin
            emit = 1'b1; e_kind = KIND_FLUSH; e_page = 5'(fhead[SW-1:0]);
            e_sync = c_sync;
          end
        end
      end
      S_RMV: begin
        if (mapped[pi] && can_emit) begin
          emit = 1'b1; e_kind = KIND_UNMAP; e_page = c_page;
          if (refs[pi] == '0) begin
            iop = Q_UNLINK; iq = pprio;
          end
          if (dirty[pi]) begin
            dop = Q_UNLINK; dq = plist;
          end
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit = 1'b1; e_val = dval; e_st = dst; e_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_LOOK;
      S_LOOK: begin
        state_next = S_DONE;
        if (c_act == ACT_CLEAR || c_act == ACT_FLUSH) state_next = S_FLUSH;
        else if (c_act == ACT_USE && here && refs[pi] != REF_MAX && refs[pi] == '0
                 && !mapped[pi]) state_next = S_EVCHK;
        else if (c_act == ACT_REMOVE && here) state_next = S_RMV;
      end
      S_EVCHK: begin
        if (!ev_cond) state_next = S_MAP;
        else if (vic != NIL) state_next = S_EVICT;
      end
      S_EVICT: if (can_emit) state_next = S_EVCHK;
      S_MAP:   if (can_emit) state_next = S_DONE;
      S_FLUSH: if (fhead == NIL) state_next = S_DONE;
      S_RMV:   if (!mapped[pi] || can_emit) state_next = S_DONE;
      S_DONE:  if (can_emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // sequencer and command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == S_IDLE && s_tvalid) begin
      c_act  <= s_tuser;
      c_page <= s_tdata[4:0];
      c_size <= s_tdata[36:5];
      c_prio <= s_tdata[39:37];
      c_list <= s_tdata[42:40];
      c_md   <= s_tdata[43];
      c_wr   <= s_tdata[44];
      c_sync <= s_tdata[45];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= 32'hFFFF_FFFF;
      levels <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIMIT:  limit  <= cfg_data;
        CFG_LEVELS: levels <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // slot table, counters and done value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        present[i] <= 1'b0;
        mapped[i]  <= 1'b0;
        dirty[i]   <= 1'b0;
        refs[i]    <= '0;
      end
      total      <= '0;
      map_events <= '0;
    end else begin
      unique case (state)
        S_LOOK: begin
          psize <= rd_size; pwr <= rd_wr; pprio <= rd_prio; plist <= rd_list;
          pr <= '0; dval <= lk_val; dst <= lk_st;
          case (c_act)
            ACT_RDMAP: map_events <= '0;
            ACT_ADD: begin
              if (pin && !present[pi]) begin
                present[pi] <= 1'b1; mapped[pi] <= 1'b0;
                refs[pi] <= '0; dirty[pi] <= 1'b0;
              end
            end
            ACT_USE: begin
              if (here && refs[pi] != REF_MAX && (refs[pi] != '0 || mapped[pi])) begin
                refs[pi] <= refs[pi] + 1'b1;
                if (c_md) dirty[pi] <= 1'b1;
              end
            end
            ACT_REL: begin
              if (here && refs[pi] != '0) refs[pi] <= refs[pi] - 1'b1;
            end
            default: ;
          endcase
        end
        S_EVCHK: if (ev_cond && vic == NIL) pr <= pr + 1'b1;
        S_EVICT: begin
          if (can_emit) begin
            dirty[vic[SW-1:0]]  <= 1'b0;
            mapped[vic[SW-1:0]] <= 1'b0;
            total <= total - TW'(rd_size);
          end
        end
        S_MAP: begin
          if (can_emit) begin
            map_events <= map_events + 32'd1;
            total <= total + TW'(psize);
            mapped[pi] <= 1'b1;
            refs[pi] <= REF_BITS'(1);
            dval <= 32'd1;
            if (c_md) dirty[pi] <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (fhead == NIL) begin
            // dval already counts the popped pages
          end else if (c_act == ACT_CLEAR || can_emit) begin
            dirty[fhead[SW-1:0]] <= 1'b0;
            dval <= dval + 32'd1;
          end
        end
        S_RMV: begin
          if (!mapped[pi] || can_emit) begin
            if (mapped[pi]) total <= total - TW'(psize);
            present[pi] <= 1'b0; mapped[pi] <= 1'b0;
            refs[pi] <= '0; dirty[pi] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // idle queue links
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        inext[i] <= NIL; iprev[i] <= NIL;
      end
      for (int j = 0; j < MAX_PRIORITIES; j++) begin
        ihead[j] <= NIL; itail[j] <= NIL;
      end
    end else begin
      case (iop)
        Q_PUSH: begin
          iprev[ix] <= itail[iq];
          inext[ix] <= NIL;
          if (itail[iq] != NIL) inext[itail[iq][SW-1:0]] <= LW'(ix);
          else ihead[iq] <= LW'(ix);
          itail[iq] <= LW'(ix);
        end
        Q_UNLINK: begin
          inext[ix] <= NIL;
          iprev[ix] <= NIL;
          if (ihead[iq] == LW'(ix)) ihead[iq] <= inext[ix];
          if (itail[iq] == LW'(ix)) itail[iq] <= iprev[ix];
          if (iprev[ix] != NIL) inext[iprev[ix][SW-1:0]] <= inext[ix];
          if (inext[ix] != NIL) iprev[inext[ix][SW-1:0]] <= iprev[ix];
        end
        default: ;
      endcase
    end
  end

  // dirty queue links
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        dnext[i] <= NIL; dprev[i] <= NIL;
      end
      for (int j = 0; j < DIRTY_LISTS; j++) begin
        dhead[j] <= NIL; dtail[j] <= NIL;
      end
    end else begin
      case (dop)
        Q_PUSH: begin
          dprev[dx] <= dtail[dq];
          dnext[dx] <= NIL;
          if (dtail[dq] != NIL) dnext[dtail[dq][SW-1:0]] <= LW'(dx);
          else dhead[dq] <= LW'(dx);
          dtail[dq] <= LW'(dx);
        end
        Q_UNLINK: begin
          dnext[dx] <= NIL;
          dprev[dx] <= NIL;
          if (dhead[dq] == LW'(dx)) dhead[dq] <= dnext[dx];
          if (dtail[dq] == LW'(dx)) dtail[dq] <= dprev[dx];
          if (dprev[dx] != NIL) dnext[dprev[dx][SW-1:0]] <= dnext[dx];
          if (dnext[dx] != NIL) dprev[dnext[dx][SW-1:0]] <= dprev[dx];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      m_tuser <= e_kind;
      m_tlast <= e_last;
      m_tdata <= {6'd0, e_st, e_val, e_sync, e_wr, e_page};
    end
  end

endmodule
`default_nettype wire

// ----- design/prm_attr_mem.sv -----
// Slot attribute memory: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module prm_attr_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 39
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- tb/sv/prm_checker.sv -----
// Scoreboard for the page residency manager: watches the input, output and
// configuration channels, predicts every result and compares it field by field.
// Depends on prm_pkg for action, kind and status codes.
`default_nettype none
module prm_checker
  import prm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [2:0]  s_tuser,
  input  wire logic [47:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [2:0]  m_tuser,
  input  wire logic        m_tlast,
  input  wire logic [47:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               results_seen
);

  localparam int NSLOT  = PageSlotsDef;
  localparam int NIL    = NSLOT;
  localparam int NPRIO  = MaxPrioritiesDef;
  localparam int NLIST  = DirtyListsDef;
  localparam int REFMAX = (1 << RefBitsDef) - 1;
  localparam int IDLEQ  = 0;
  localparam int DIRTQ  = 1;

  typedef struct {
    logic [2:0]  kind;
    logic [4:0]  page;
    logic        wr;
    logic        sy;
    logic [31:0] value;
    logic [2:0]  status;
    logic        last;
  } page_event_t;

  page_event_t       expected_q[$];

  // predicted table state
  bit                pg_present [NSLOT];
  logic [31:0]       pg_size    [NSLOT];
  int                pg_prio    [NSLOT];
  bit                pg_wr      [NSLOT];
  int                pg_list    [NSLOT];
  bit                pg_mapped  [NSLOT];
  int                pg_refs    [NSLOT];
  bit                pg_dirty   [NSLOT];
  int                lnk_next   [2][NSLOT];
  int                lnk_prev   [2][NSLOT];
  int                q_head     [2][16];
  int                q_tail     [2][16];
  longint unsigned   mapped_total;
  logic [31:0]       map_count;
  logic [31:0]       limit_reg;
  logic [3:0]        levels_reg;

  assign pending = expected_q.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic void clear_state();
    for (int i = 0; i < NSLOT; i++) begin
      pg_present[i] = 0; pg_size[i] = '0; pg_prio[i] = 0; pg_wr[i] = 0;
      pg_list[i] = 0; pg_mapped[i] = 0; pg_refs[i] = 0; pg_dirty[i] = 0;
      for (int k = 0; k < 2; k++) begin
        lnk_next[k][i] = NIL;
        lnk_prev[k][i] = NIL;
      end
    end
    for (int k = 0; k < 2; k++)
      for (int j = 0; j < 16; j++) begin
        q_head[k][j] = NIL;
        q_tail[k][j] = NIL;
      end
    mapped_total = 0;
    map_count    = '0;
    limit_reg    = 32'hFFFF_FFFF;
    levels_reg   = 4'd8;
    expected_q.delete();
  endfunction

  function automatic void link_append(int k, int q, int p);
    int t;
    t = q_tail[k][q];
    lnk_prev[k][p] = t;
    lnk_next[k][p] = NIL;
    if (t < NSLOT) lnk_next[k][t] = p;
    else q_head[k][q] = p;
    q_tail[k][q] = p;
  endfunction

  function automatic void link_remove(int k, int q, int p);
    int n, b;
    n = lnk_next[k][p];
    b = lnk_prev[k][p];
    lnk_next[k][p] = NIL;
    lnk_prev[k][p] = NIL;
    if (q_head[k][q] == p) q_head[k][q] = n;
    if (q_tail[k][q] == p) q_tail[k][q] = b;
    if (b < NSLOT) lnk_next[k][b] = n;
    if (n < NSLOT) lnk_prev[k][n] = b;
  endfunction

  function automatic int link_pop(int k, int q);
    int h;
    h = q_head[k][q];
    if (h >= NSLOT) return NIL;
    link_remove(k, q, h);
    return h;
  endfunction

  function automatic void push_event(logic [2:0] kind, int page, bit wr, bit sy,
                                     logic [31:0] value, logic [2:0] status, bit last);
    page_event_t e;
    e.kind = kind; e.page = page[4:0]; e.wr = wr; e.sy = sy;
    e.value = value; e.status = status; e.last = last;
    expected_q.push_back(e);
  endfunction

  function automatic void push_done(logic [31:0] value, logic [2:0] status);
    push_event(KIND_DONE, 0, 0, 0, value, status, 1);
  endfunction

  // work out the results of one accepted action and advance the table
  function automatic void predict_action(logic [2:0] act, logic [47:0] d);
    int          p, lv, pr, v, q, cnt;
    logic [31:0] sz;
    int          prio, list;
    bit          mdirty, wr, sy, make_dirty;
    p      = d[4:0];
    sz     = d[36:5];
    prio   = d[39:37];
    list   = d[42:40];
    mdirty = d[43];
    wr     = d[44];
    sy     = d[45];
    case (act)
      ACT_RDUSE: begin
        if (!pg_present[p]) push_done(0, ST_ABSENT);
        else push_done(pg_refs[p], ST_OK);
      end
      ACT_RDMAP: begin
        push_done(map_count, ST_OK);
        map_count = '0;
      end
      ACT_CLEAR, ACT_FLUSH: begin
        cnt = 0;
        if (list < NLIST) begin
          q = link_pop(DIRTQ, list);
          while (q < NSLOT) begin
            pg_dirty[q] = 0;
            cnt++;
            if (act == ACT_FLUSH) push_event(KIND_FLUSH, q, 0, sy, 0, ST_OK, 0);
            q = link_pop(DIRTQ, list);
          end
        end
        push_done(cnt, ST_OK);
      end
      ACT_ADD: begin
        if (pg_present[p]) push_done(0, ST_BUSY);
        else begin
          pg_present[p] = 1;
          pg_size[p]    = sz;
          pg_prio[p]    = (prio < NPRIO) ? prio : NPRIO - 1;
          pg_wr[p]      = wr;
          pg_list[p]    = (list < NLIST) ? list : NLIST - 1;
          pg_mapped[p]  = 0;
          pg_refs[p]    = 0;
          pg_dirty[p]   = 0;
          for (int k = 0; k < 2; k++) begin
            lnk_next[k][p] = NIL;
            lnk_prev[k][p] = NIL;
          end
          push_done(0, ST_OK);
        end
      end
      default: begin
        if (!pg_present[p]) push_done(0, ST_ABSENT);
        else if (act == ACT_USE) begin
          make_dirty = mdirty && !pg_dirty[p];
          if (pg_refs[p] >= REFMAX) push_done(pg_refs[p], ST_FULL);
          else begin
            if (pg_refs[p] == 0) begin
              if (!pg_mapped[p]) begin
                lv = levels_reg;
                if (lv < 1) lv = 1;
                if (lv > NPRIO) lv = NPRIO;
                pr = 0;
                // evict oldest idle pages, lowest queue first
                while (mapped_total + pg_size[p] >= longint'(limit_reg) && pr < lv) begin
                  v = link_pop(IDLEQ, pr);
                  if (v >= NSLOT) pr++;
                  else begin
                    push_event(KIND_EVICT, v, 0, 0, 0, ST_OK, 0);
                    if (pg_dirty[v] && pg_list[v] < NLIST)
                      link_remove(DIRTQ, pg_list[v], v);
                    pg_dirty[v]  = 0;
                    pg_mapped[v] = 0;
                    mapped_total -= pg_size[v];
                  end
                end
                map_count++;
                push_event(KIND_MAP, p, pg_wr[p], 0, 0, ST_OK, 0);
                mapped_total += pg_size[p];
                pg_mapped[p] = 1;
              end else if (pg_prio[p] < NPRIO) begin
                link_remove(IDLEQ, pg_prio[p], p);
              end
            end
            pg_refs[p]++;
            if (make_dirty) begin
              pg_dirty[p] = 1;
              if (pg_list[p] < NLIST) link_append(DIRTQ, pg_list[p], p);
            end
            push_done(pg_refs[p], ST_OK);
          end
        end else if (act == ACT_REL) begin
          if (pg_refs[p] == 0) push_done(0, ST_UNUSED);
          else begin
            pg_refs[p]--;
            if (pg_refs[p] == 0 && pg_prio[p] < NPRIO)
              link_append(IDLEQ, pg_prio[p], p);
            push_done(pg_refs[p], ST_OK);
          end
        end else begin
          // remove, allowed while in use
          if (pg_mapped[p]) begin
            if (pg_refs[p] == 0 && pg_prio[p] < NPRIO)
              link_remove(IDLEQ, pg_prio[p], p);
            if (pg_dirty[p] && pg_list[p] < NLIST)
              link_remove(DIRTQ, pg_list[p], p);
            mapped_total -= pg_size[p];
            push_event(KIND_UNMAP, p, 0, 0, 0, ST_OK, 0);
          end
          pg_present[p] = 0;
          pg_mapped[p]  = 0;
          pg_refs[p]    = 0;
          pg_dirty[p]   = 0;
          for (int k = 0; k < 2; k++) begin
            lnk_next[k][p] = NIL;
            lnk_prev[k][p] = NIL;
          end
          push_done(0, ST_OK);
        end
      end
    endcase
  endfunction

  initial begin
    errors       = 0;
    results_seen = 0;
  end

  // compare outputs, then track config writes and accepted actions
  always @(posedge clk) begin
    page_event_t e;
    if (rst) clear_state();
    else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) report_mismatch("unexpected result kind", m_tuser, 0);
        else begin
          e = expected_q.pop_front();
          if (m_tuser != e.kind)          report_mismatch("kind", m_tuser, e.kind);
          if (m_tdata[4:0] != e.page)     report_mismatch("page_out", m_tdata[4:0], e.page);
          if (m_tdata[5] != e.wr)         report_mismatch("writable_out", m_tdata[5], e.wr);
          if (m_tdata[6] != e.sy)         report_mismatch("sync_out", m_tdata[6], e.sy);
          if (m_tdata[38:7] != e.value)   report_mismatch("value", m_tdata[38:7], e.value);
          if (m_tdata[41:39] != e.status) report_mismatch("status", m_tdata[41:39], e.status);
          if (m_tlast != e.last)          report_mismatch("last", m_tlast, e.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LIMIT) limit_reg = cfg_data;
        else levels_reg = cfg_data[3:0];
      end
      if (s_tvalid && s_tready) predict_action(s_tuser, s_tdata);
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Top of the page residency manager testbench: clock, reset, stimulus and verdict.
// Depends on prm_pkg, page_residency_manager and prm_checker.
`default_nettype none
module testbench;
  import prm_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [2:0]  s_tuser = '0;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic [47:0] m_tdata;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_data = '0;

  int errors, pending, results_seen;
  int actions_sent = 0;
  bit idle_on = 1;
  bit hold_req = 0;

  always #2 clk = ~clk;

  page_residency_manager u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tuser, .m_tlast, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  prm_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tuser, .m_tlast, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .results_seen
  );

  // result channel backpressure: random bursts, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      if (stall > 0) begin
        m_tready <= 0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 0;
        stall = $urandom_range(0, 12);
      end else m_tready <= 1;
    end
  end

  // offer one action and hold it until the block accepts it
  task automatic send_action(logic [2:0] act, logic [4:0] page, logic [31:0] sz,
                             logic [2:0] prio, logic [2:0] list, bit md, bit wr, bit sy);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, sy, wr, md, list, prio, sz, page};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    actions_sent++;
    @(negedge clk);
  endtask

  // drain all results, let the block settle, then write one register
  task automatic write_reg(logic idx, logic [31:0] val);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 0;
  endtask

  task automatic random_action();
    logic [2:0]  act;
    logic [4:0]  page;
    logic [31:0] sz;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 18)      act = ACT_ADD;
    else if (r < 48) act = ACT_USE;
    else if (r < 72) act = ACT_REL;
    else if (r < 80) act = ACT_REMOVE;
    else if (r < 85) act = ACT_CLEAR;
    else if (r < 91) act = ACT_FLUSH;
    else if (r < 96) act = ACT_RDUSE;
    else             act = ACT_RDMAP;
    page = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 9)) : 5'($urandom_range(0, 31));
    r = $urandom_range(0, 9);
    if (r < 7)       sz = $urandom_range(1, 64);
    else if (r < 9)  sz = $urandom | 32'd1;
    else             sz = 32'hFFFF_FFFF;
    send_action(act, page, sz, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [31:0] limits [7];
    logic [3:0]  levels [7];
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: busy add, dirty marking, eviction order, flush, clear, absent pages
    write_reg(CFG_LIMIT, 32'd40);
    send_action(ACT_ADD,    0, 10, 0, 2, 0, 1, 0);
    send_action(ACT_ADD,    0, 10, 0, 2, 0, 1, 0);
    send_action(ACT_ADD,    1, 20, 1, 2, 0, 0, 0);
    send_action(ACT_ADD,    2, 30, 7, 7, 0, 1, 1);
    send_action(ACT_USE,    0, 0, 0, 0, 1, 0, 0);
    send_action(ACT_USE,    0, 0, 0, 0, 1, 0, 0);
    send_action(ACT_USE,    1, 0, 0, 0, 1, 0, 0);
    send_action(ACT_REL,    0, 0, 0, 0, 0, 0, 0);
    send_action(ACT_REL,    0, 0, 0, 0, 0, 0, 0);
    send_action(ACT_REL,    0, 0, 0, 0, 0, 0, 0);
    send_action(ACT_REL,    1, 0, 0, 0, 0, 0, 0);
    send_action(ACT_RDUSE,  0, 0, 0, 0, 0, 0, 0);
    send_action(ACT_USE,    2, 0, 0, 0, 0, 0, 0);
    send_action(ACT_FLUSH,  0, 0, 0, 2, 0, 0, 1);
    send_action(ACT_USE,    2, 0, 0, 0, 1, 0, 0);
    send_action(ACT_FLUSH,  0, 0, 0, 7, 0, 0, 1);
    send_action(ACT_USE,    2, 0, 0, 0, 1, 0, 0);
    send_action(ACT_REMOVE, 2, 0, 0, 0, 0, 0, 0);
    send_action(ACT_CLEAR,  0, 0, 0, 7, 0, 0, 0);
    send_action(ACT_RDUSE,  5, 0, 0, 0, 0, 0, 0);
    send_action(ACT_USE,    5, 0, 0, 0, 0, 0, 0);
    send_action(ACT_REL,    5, 0, 0, 0, 0, 0, 0);
    send_action(ACT_REMOVE, 5, 0, 0, 0, 0, 0, 0);
    send_action(ACT_RDMAP,  0, 0, 0, 0, 0, 0, 0);
    send_action(ACT_RDMAP,  0, 0, 0, 0, 0, 0, 0);

    // random phases over limit and level settings, extremes included
    limits = '{32'hFFFF_FFFF, 32'd0, 32'd200, 32'd0, 32'd1000, $urandom, 32'hFFFF_FFFF};
    levels = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd8};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_LIMIT, limits[ph]);
      write_reg(CFG_LEVELS, {28'd0, levels[ph]});
      if (ph == 6) idle_on = 0;
      for (int i = 0; i < 62; i++) begin
        if (ph == 2 && i == 10) hold_req = 1;
        random_action();
      end
    end

    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d actions and %0d results over 7 limit and level settings",
             actions_sent, results_seen);
    $display("including eviction, dirty flush and clear, and a long output stall");
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  // timeout
  initial begin
    #16000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
